>>> src/lcdw_pkg.sv
// Shared types, constants and the error-text table of the character LCD text writer.
package lcdw_pkg;

  // Kind of work handed from the front part to the back part
  typedef enum logic [0:0] {
    CMD_CHAR = 1'b0,
    CMD_ERR  = 1'b1
  } cmd_kind_e;

  // One queued command: a character at a cursor position, or the error text
  typedef struct packed {
    cmd_kind_e  kind;
    logic       row;
    logic [3:0] col;
    logic [7:0] ch;
  } cmd_t;

  localparam int unsigned ErrLen = 12;
  localparam logic [3:0] ErrLastIdx = 4'(ErrLen - 1);

  // Set-address command bases for row 1 and row 2
  localparam logic [7:0] AddrRow1 = 8'h80;
  localparam logic [7:0] AddrRow2 = 8'hC0;

  // Register-select codes on the bus
  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;

  // Error text "(1,1)~(2,16)", one character per index
  function automatic logic [7:0] err_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h28;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h2C;
      4'd3:    c = 8'h31;
      4'd4:    c = 8'h29;
      4'd5:    c = 8'h7E;
      4'd6:    c = 8'h28;
      4'd7:    c = 8'h32;
      4'd8:    c = 8'h2C;
      4'd9:    c = 8'h31;
      4'd10:   c = 8'h36;
      4'd11:   c = 8'h29;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

>>> src/lcdw_front.sv
// Front part: accepts string items, tracks the cursor and queues print commands.
module lcdw_front import lcdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       first_i,
  input  logic [1:0] row_i,
  input  logic [4:0] column_i,
  input  logic       no_char_i,
  input  logic [7:0] character_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  logic       cur_row_q, cur_row_d;
  logic [3:0] cur_col_q, cur_col_d;
  logic       rejected_q, rejected_d;

  logic       accept;
  logic       pos_ok;
  logic [4:0] col_m1;
  logic       eff_row;
  logic [3:0] eff_col;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign pos_ok     = (row_i == 2'd1 || row_i == 2'd2) &&
                      (column_i != 5'd0) && (column_i <= 5'd16);
  assign col_m1     = column_i - 5'd1;

  // Start position taken from a first item, else the held cursor
  assign eff_row = first_i ? (row_i == 2'd2) : cur_row_q;
  assign eff_col = first_i ? col_m1[3:0] : cur_col_q;

  // Classify the item and work out the cursor after it
  always_comb begin
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    rejected_d = rejected_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CMD_CHAR, row: eff_row, col: eff_col, ch: character_i};
    if (accept) begin
      if (first_i && !pos_ok) begin
        rejected_d      = 1'b1;
        push_o          = 1'b1;
        push_cmd_o.kind = CMD_ERR;
      end else if (first_i || !rejected_q) begin
        if (first_i) begin
          rejected_d = 1'b0;
        end
        cur_row_d = eff_row;
        cur_col_d = eff_col;
        if (!no_char_i) begin
          push_o = 1'b1;
          if (eff_col == 4'd15) begin
            cur_col_d = 4'd0;
            cur_row_d = ~eff_row;
          end else begin
            cur_col_d = eff_col + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q  <= 1'b0;
      cur_col_q  <= 4'd0;
      rejected_q <= 1'b0;
    end else begin
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      rejected_q <= rejected_d;
    end
  end

endmodule

>>> src/lcdw_queue.sv
// Short command queue between the front and back parts, head readable at once.
module lcdw_queue import lcdw_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command queue read while empty");
`endif

endmodule

>>> src/lcdw_back.sv
// Back part: expands queued commands into bus transfers, one per cycle while the output is free.
module lcdw_back import lcdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       four_bit_i,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_rs_o,
  output logic [7:0] out_value_o,
  output logic       out_last_o
);

  logic [3:0] idx_q, idx_d;
  logic       byte_q, byte_d;
  logic       nib_q, nib_d;
  logic       ov_q, ov_d;
  logic       rs_q;
  logic [7:0] val_q;
  logic       last_q;

  logic       slot_free;
  logic       issue;
  logic       is_err;
  logic       t_row;
  logic [3:0] t_col;
  logic [7:0] t_char;
  logic [7:0] t_byte;
  logic [7:0] t_value;
  logic       byte_done;
  logic       t_last;

  assign slot_free = ~ov_q | out_ready_i;
  assign issue     = head_valid_i & slot_free;
  assign is_err    = (head_i.kind == CMD_ERR);

  // Build the current transfer from the head command and the step counters
  assign t_row     = is_err ? 1'b0 : head_i.row;
  assign t_col     = is_err ? idx_q : head_i.col;
  assign t_char    = is_err ? err_char(idx_q) : head_i.ch;
  assign t_byte    = byte_q ? t_char : ((t_row ? AddrRow2 : AddrRow1) | {4'd0, t_col});
  assign t_value   = !four_bit_i ? t_byte :
                     (nib_q ? {t_byte[3:0], 4'd0} : {t_byte[7:4], 4'd0});
  assign byte_done = ~four_bit_i | nib_q;
  assign t_last    = byte_q & byte_done & (!is_err || idx_q == ErrLastIdx);
  assign pop_o     = issue & t_last;

  // Step nibble, byte and character counters
  always_comb begin
    idx_d  = idx_q;
    byte_d = byte_q;
    nib_d  = nib_q;
    ov_d   = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (issue) begin
      ov_d  = 1'b1;
      nib_d = four_bit_i & ~nib_q;
      if (byte_done) begin
        byte_d = ~byte_q;
        if (byte_q) begin
          idx_d = t_last ? 4'd0 : idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 4'd0;
      byte_q <= 1'b0;
      nib_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      byte_q <= byte_d;
      nib_q  <= nib_d;
      ov_q   <= ov_d;
    end
  end

  // Hold the transfer in the output register until taken
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rs_q   <= byte_q ? RsData : RsCommand;
      val_q  <= t_value;
      last_q <= t_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_rs_o    = rs_q;
  assign out_value_o = val_q;
  assign out_last_o  = last_q;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= ErrLastIdx)
    else $error("error text index out of range");
  a_char_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_i.kind == CMD_CHAR) |-> (idx_q == 4'd0))
    else $error("character command with non-zero text index");
  a_nibble_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !four_bit_i |-> !nib_q)
    else $error("nibble phase set in byte mode");
`endif

endmodule

>>> src/char_lcd_text_cursor_writer_core.sv
// Top level of the character LCD text writer: ports, mode register and part wiring.
// Path: an accepted character item is written into the command queue, then the back part
// loads its first transfer into its output register, from which the receiver takes it.
// Throughput: one transfer per cycle from the output register while the receiver takes
// them; a character gives 2 transfers (4 in nibble mode), an invalid start 24 (48), empty items none.
// Reset (asynchronous, active low): cursor row 1 column 1, byte mode, queue empty.
module char_lcd_text_cursor_writer_core import lcdw_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // four_bit_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // row[1:0], column[6:2], character[14:7], zero[15]
  input  logic [1:0]  s_axis_tuser,    // first[0], no_char[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // bus_value[7:0]
  output logic [0:0]  m_axis_tuser,    // reg_select[0]
  output logic        m_axis_tlast
);

  logic four_bit_q;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic q_empty;
  logic q_full;
  logic rs;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q <= 1'b0;
    end else if (cfg_we_i) begin
      four_bit_q <= cfg_wdata_i;
    end
  end

  lcdw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .first_i     (s_axis_tuser[0]),
    .row_i       (s_axis_tdata[1:0]),
    .column_i    (s_axis_tdata[6:2]),
    .no_char_i   (s_axis_tuser[1]),
    .character_i (s_axis_tdata[14:7]),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  lcdw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  lcdw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .four_bit_i   (four_bit_q),
    .head_valid_i (~q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (rs),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = rs;

endmodule

>>> tb/tb_char_lcd_text_cursor_writer_core.sv
// Self-checking testbench for the character LCD text writer core.
module tb_char_lcd_text_cursor_writer_core import lcdw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One input item of a string
  typedef struct {
    logic       first;
    logic [1:0] row;
    logic [4:0] column;
    logic       no_char;
    logic [7:0] ch;
  } text_item_t;

  // One bus transfer towards the display
  typedef struct {
    logic       rs;
    logic [7:0] bus;
    logic       fin;
  } bus_xfer_t;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 8;

  // Error text "(1,1)~(2,16)"
  localparam logic [7:0] ErrText [12] = '{
    8'h28, 8'h31, 8'h2C, 8'h31, 8'h29, 8'h7E, 8'h28, 8'h32, 8'h2C, 8'h31, 8'h36, 8'h29
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // row[1:0], column[6:2], character[14:7], zero[15]
  logic [1:0]  s_axis_tuser = '0;  // first[0], no_char[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // bus_value[7:0]
  logic [0:0]  m_axis_tuser;       // reg_select[0]
  logic        m_axis_tlast;

  // Stimulus and expectation stores
  text_item_t  pending_items[$];
  bus_xfer_t   xfer_q[$];
  text_item_t  drv_item;
  bus_xfer_t   want;
  int unsigned items_total = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;

  // Side-band controls from the sequence to the driver and receiver
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  // Predictor state
  logic       nibble_mode = 1'b0;
  logic       cur_row = 1'b0;
  logic [3:0] cur_col = 4'd0;
  logic       str_rejected = 1'b0;

  char_lcd_text_cursor_writer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic pos_ok(logic [1:0] r, logic [4:0] c);
    return (r == 2'd1 || r == 2'd2) && c >= 5'd1 && c <= 5'd16;
  endfunction

  // Queue one byte as one or two transfers
  function automatic void push_byte(logic rs, logic [7:0] b);
    if (nibble_mode) begin
      xfer_q.push_back('{rs: rs, bus: {b[7:4], 4'h0}, fin: 1'b0});
      xfer_q.push_back('{rs: rs, bus: {b[3:0], 4'h0}, fin: 1'b0});
    end else begin
      xfer_q.push_back('{rs: rs, bus: b, fin: 1'b0});
    end
  endfunction

  // Set-address command followed by the data write
  function automatic void push_char(logic r, logic [3:0] c, logic [7:0] ch);
    push_byte(RsCommand, (r ? AddrRow2 : AddrRow1) + {4'h0, c});
    push_byte(RsData, ch);
  endfunction

  // Work out the transfers of one accepted item and advance the cursor
  function automatic void predict_transfers(text_item_t it);
    if (it.first) begin
      if (!pos_ok(it.row, it.column)) begin
        for (int i = 0; i < 12; i++) push_char(1'b0, 4'(i), ErrText[i]);
        str_rejected = 1'b1;
        xfer_q[xfer_q.size() - 1].fin = 1'b1;
        return;
      end
      cur_row = it.row[1];
      cur_col = 4'(it.column - 5'd1);
      str_rejected = 1'b0;
    end else if (str_rejected) begin
      return;
    end
    if (it.no_char) return;
    push_char(cur_row, cur_col, it.ch);
    if (cur_col == 4'd15) begin
      cur_col = 4'd0;
      cur_row = ~cur_row;
    end else begin
      cur_col = cur_col + 4'd1;
    end
    xfer_q[xfer_q.size() - 1].fin = 1'b1;
  endfunction

  task automatic flag_mismatch(string what);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic add_item(logic first, logic [1:0] row, logic [4:0] column, logic no_char,
                          logic [7:0] ch);
    pending_items.push_back('{first: first, row: row, column: column, no_char: no_char, ch: ch});
    items_total++;
  endtask

  // Mostly well-formed strings with random content, some noise and bad starts
  task automatic add_random_strings(int unsigned goal);
    int unsigned made;
    int unsigned len;
    logic        bad;
    logic [1:0]  r;
    logic [4:0]  c;
    made = 0;
    while (made < goal) begin
      if ($urandom_range(99) < 8) begin
        add_item(1'($urandom), 2'($urandom), 5'($urandom), 1'($urandom), 8'($urandom));
        made++;
      end else begin
        bad = ($urandom_range(99) < 12);
        if (bad) begin
          do begin
            r = 2'($urandom);
            c = 5'($urandom);
          end while (pos_ok(r, c));
        end else begin
          r = 2'($urandom_range(2, 1));
          c = 5'($urandom_range(16, 1));
        end
        add_item(1'b1, r, c, 1'($urandom_range(99) < 6), 8'($urandom));
        made++;
        len = $urandom_range(20);
        repeat (len) begin
          add_item(1'b0, 2'($urandom), 5'($urandom), 1'b0, 8'($urandom));
          made++;
        end
        if ($urandom_range(99) < 30) begin
          add_item(1'b0, 2'($urandom), 5'($urandom), 1'b1, 8'($urandom));
          made++;
        end
      end
    end
  endtask

  // Hold until every item is taken and every transfer has come, then settle
  task automatic wait_drained();
    while (items_taken != items_total || xfer_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the mode register while the block is idle
  task automatic set_mode(logic mode);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    nibble_mode = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sequence: reset, directed strings, then random phases across both modes
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(1'b0);
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'h41);   // no start given yet: row 1 column 1
    add_item(1'b0, 2'd3, 5'd31, 1'b0, 8'h00);  // character zero prints as usual
    add_item(1'b1, 2'd1, 5'd1, 1'b0, 8'hFF);
    add_item(1'b1, 2'd2, 5'd16, 1'b0, 8'h5A);  // last cell, wraps to row 1
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'h33);
    add_item(1'b1, 2'd0, 5'd5, 1'b0, 8'h44);   // bad row
    add_item(1'b0, 2'd1, 5'd1, 1'b0, 8'h45);   // ignored after bad start
    add_item(1'b0, 2'd1, 5'd1, 1'b1, 8'h46);
    add_item(1'b1, 2'd3, 5'd31, 1'b1, 8'h47);  // bad start with no character
    add_item(1'b1, 2'd1, 5'd0, 1'b0, 8'h48);   // column zero
    add_item(1'b1, 2'd2, 5'd17, 1'b0, 8'h49);  // column past the end
    add_item(1'b1, 2'd1, 5'd16, 1'b0, 8'h4A);  // row 1 end wraps to row 2
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'h4B);
    add_item(1'b1, 2'd2, 5'd5, 1'b1, 8'h4C);   // empty string still moves the cursor
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'h4D);
    add_item(1'b0, 2'd0, 5'd0, 1'b1, 8'h4E);   // empty item
    add_item(1'b1, 2'd2, 5'd15, 1'b0, 8'hA5);
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'h5A);
    add_item(1'b0, 2'd0, 5'd0, 1'b0, 8'hC3);

    set_mode(1'b1);
    add_random_strings(90);

    // Long receiver hold-off while the sender keeps offering
    set_mode(1'b0);
    add_random_strings(100);
    @(posedge clk_i);
    hold_req <= ~hold_req;

    // Run without any idling on either side
    set_mode(1'b1);
    @(posedge clk_i);
    no_idle <= 1'b1;
    add_random_strings(90);
    wait_drained();
    no_idle <= 1'b0;

    set_mode(1'b0);
    add_random_strings(90);

    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: offer the next pending item when the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 7)) begin
        drv_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, drv_item.ch, drv_item.column, drv_item.row};
        s_axis_tuser  <= {drv_item.no_char, drv_item.first};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure and one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_axis_tready <= 1'b0;
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  // Monitor: predict on accepted items, check accepted transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        predict_transfers('{first: s_axis_tuser[0], row: s_axis_tdata[1:0],
                            column: s_axis_tdata[6:2], no_char: s_axis_tuser[1],
                            ch: s_axis_tdata[14:7]});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (xfer_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer rs=%0b bus=%02h last=%0b",
                                  m_axis_tuser[0], m_axis_tdata, m_axis_tlast));
        end else begin
          want = xfer_q.pop_front();
          if (m_axis_tuser[0] !== want.rs)
            flag_mismatch($sformatf("reg_select %0b, expected %0b", m_axis_tuser[0], want.rs));
          if (m_axis_tdata !== want.bus)
            flag_mismatch($sformatf("bus_value %02h, expected %02h", m_axis_tdata, want.bus));
          if (m_axis_tlast !== want.fin)
            flag_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.fin));
        end
      end
    end
  end

endmodule
